/* src/cba_pkg.sv */
// cba_pkg: shared constants and types for the chunk bitmap allocator
// used by cba_ffs and chunk_bitmap_allocator; depends on nothing
package cba_pkg;

	localparam int NUM_CHUNKS_DEF = 64;
	localparam int MAX_GRANT      = 64;

	// bitmap row width used by the scan
	localparam int WORD_W   = 8;
	localparam int WORD_LOG = 3;

	// item kinds
	localparam logic [1:0] KIND_ALLOC   = 2'd0;
	localparam logic [1:0] KIND_CLAIM   = 2'd1;
	localparam logic [1:0] KIND_RELEASE = 2'd2;
	localparam logic [1:0] KIND_UNUSED  = 2'd3;

	// result status codes
	localparam logic [2:0] ST_GRANT = 3'd0;
	localparam logic [2:0] ST_DONE  = 3'd1;
	localparam logic [2:0] ST_SHORT = 3'd2;
	localparam logic [2:0] ST_TAKEN = 3'd3;
	localparam logic [2:0] ST_FREE  = 3'd4;

	typedef struct packed {
		logic                found;
		logic [WORD_LOG-1:0] idx;
	} ffs_t;

endpackage

/* src/cba_ffs.sv */
// cba_ffs: find-first-set over one bitmap row, lowest index wins
// depends on cba_pkg
module cba_ffs (
	input  logic [cba_pkg::WORD_W-1:0] word,
	output cba_pkg::ffs_t              hit
);
	import cba_pkg::*;

	always_comb begin
		hit.found = |word;
		hit.idx   = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (word[i]) begin
				hit.idx = WORD_LOG'(i);
			end
		end
	end

endmodule

/* src/chunk_bitmap_allocator.sv */
// chunk_bitmap_allocator: first-fit allocator over a pool of equal chunks
// depends on cba_pkg and cba_ffs
//
// One item is taken when start is high and busy is low; results appear on
// status, granted_id, last and free_left for one cycle each with result_valid
// high, and the receiver cannot stall them. The free bitmap sits in a memory of
// 8-bit rows with a registered read port; rows carry a valid bit so that a row
// never written reads as all free, and no clearing pass follows reset. An
// allocate of N chunks is accepted and then grants chunks one by one from the
// current row; every row it moves past is read and then found exhausted by the
// scan, and the row holding the final grant is read before it is scanned; the
// final grant ends the item. Claim and release pass through acceptance, a row
// read and an update. Rejected items, a zero count and ids outside the pool
// answer in the cycle after acceptance; kind 3 gives no result.
// The row read and the single find-first-set unit set the steps above.
module chunk_bitmap_allocator #(
	parameter int NUM_CHUNKS = cba_pkg::NUM_CHUNKS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] kind,
	input  logic [6:0] chunk_count,
	input  logic [5:0] chunk_id,
	output logic       result_valid,
	output logic [2:0] status,
	output logic [5:0] granted_id,
	output logic       last,
	output logic [6:0] free_left
);
	import cba_pkg::*;

	localparam int NUM_WORDS = (NUM_CHUNKS + WORD_W - 1) / WORD_W;
	localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int FT_W      = $clog2(NUM_CHUNKS + 1);
	localparam int CW        = (FT_W > 7) ? FT_W : 7;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_SCAN,
		S_UPDATE
	} state_t;

	state_t              state_q;
	logic [1:0]          op_q;
	logic [5:0]          id_q;
	logic [AW-1:0]       addr_q;
	logic [6:0]          rem_q;
	logic [WORD_W-1:0]   word_q;
	logic [FT_W-1:0]     free_total_q;
	logic [NUM_WORDS-1:0] row_valid_q;

	logic [WORD_W-1:0]   mem_q [NUM_WORDS];
	logic [WORD_W-1:0]   rd_word_q;
	logic                rd_vld_q;

	logic                result_valid_q;
	logic [2:0]          status_q;
	logic [5:0]          granted_id_q;
	logic                last_q;
	logic [6:0]          free_left_q;

	logic [AW-1:0]       rd_addr;
	logic [AW-1:0]       row_of_id;
	logic [5:0]          id_shift;
	logic                id_in_pool;
	logic                too_many;
	ffs_t                ffs;
	logic [WORD_W-1:0]   grant_mask;
	logic [WORD_W-1:0]   upd_mask;
	logic                cur_bit;
	logic                mem_we;
	logic [WORD_W-1:0]   wr_data;
	logic [FT_W-1:0]     ft_dec;
	logic [FT_W-1:0]     ft_inc;
	logic [AW+WORD_LOG-1:0] full_id;

	cba_ffs u_ffs (
		.word (word_q),
		.hit  (ffs)
	);

	assign id_shift   = chunk_id >> WORD_LOG;
	assign row_of_id  = AW'(id_shift);
	assign id_in_pool = (32'(chunk_id) < NUM_CHUNKS);
	assign too_many   = (chunk_count > 7'(MAX_GRANT))
		|| (CW'(free_total_q) < CW'(chunk_count));
	assign grant_mask = WORD_W'(1) << ffs.idx;
	assign upd_mask   = WORD_W'(1) << id_q[WORD_LOG-1:0];
	assign cur_bit    = word_q[id_q[WORD_LOG-1:0]];
	assign ft_dec     = free_total_q - FT_W'(1);
	assign ft_inc     = free_total_q + FT_W'(1);
	assign full_id    = {addr_q, ffs.idx};

	always_comb begin
		if (state_q == S_SCAN) begin
			rd_addr = addr_q + AW'(1);
		end else if (kind == KIND_ALLOC) begin
			rd_addr = '0;
		end else begin
			rd_addr = row_of_id;
		end
	end

	// write back a row when it runs dry, at the last grant, or on a claim/release that changes the bit
	always_comb begin
		mem_we  = 1'b0;
		wr_data = word_q & ~grant_mask;
		case (state_q)
			S_SCAN: begin
				mem_we = !ffs.found || (rem_q == 7'd1);
			end
			S_UPDATE: begin
				mem_we  = (op_q == KIND_CLAIM) ? cur_bit : !cur_bit;
				wr_data = word_q ^ upd_mask;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[addr_q] <= wr_data;
		end
		rd_word_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			op_q           <= KIND_ALLOC;
			id_q           <= '0;
			addr_q         <= '0;
			rem_q          <= '0;
			word_q         <= '0;
			free_total_q   <= FT_W'(NUM_CHUNKS);
			row_valid_q    <= '0;
			rd_vld_q       <= 1'b0;
			result_valid_q <= 1'b0;
			status_q       <= ST_DONE;
			granted_id_q   <= '0;
			last_q         <= 1'b0;
			free_left_q    <= '0;
		end else begin
			result_valid_q <= 1'b0;
			rd_vld_q       <= row_valid_q[rd_addr];
			if (mem_we) begin
				row_valid_q[addr_q] <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q   <= kind;
						id_q   <= chunk_id;
						addr_q <= rd_addr;
						rem_q  <= chunk_count;
						granted_id_q <= '0;
						last_q       <= 1'b1;
						free_left_q  <= 7'(free_total_q);
						case (kind)
							KIND_ALLOC: begin
								if (chunk_count == 7'd0) begin
									result_valid_q <= 1'b1;
									status_q       <= ST_DONE;
								end else if (too_many) begin
									result_valid_q <= 1'b1;
									status_q       <= ST_SHORT;
								end else begin
									state_q <= S_READ;
								end
							end
							KIND_CLAIM: begin
								if (!id_in_pool) begin
									result_valid_q <= 1'b1;
									status_q       <= ST_TAKEN;
								end else begin
									state_q <= S_READ;
								end
							end
							KIND_RELEASE: begin
								if (!id_in_pool) begin
									result_valid_q <= 1'b1;
									status_q       <= ST_FREE;
								end else begin
									state_q <= S_READ;
								end
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_READ: begin
					// a row never written holds all free chunks
					word_q  <= rd_vld_q ? rd_word_q : '1;
					state_q <= (op_q == KIND_ALLOC) ? S_SCAN : S_UPDATE;
				end
				S_SCAN: begin
					if (ffs.found) begin
						word_q         <= word_q & ~grant_mask;
						free_total_q   <= ft_dec;
						rem_q          <= rem_q - 7'd1;
						result_valid_q <= 1'b1;
						status_q       <= ST_GRANT;
						granted_id_q   <= 6'(full_id);
						last_q         <= (rem_q == 7'd1);
						free_left_q    <= 7'(ft_dec);
						if (rem_q == 7'd1) begin
							state_q <= S_IDLE;
						end
					end else begin
						addr_q  <= rd_addr;
						state_q <= S_READ;
					end
				end
				S_UPDATE: begin
					result_valid_q <= 1'b1;
					granted_id_q   <= '0;
					last_q         <= 1'b1;
					state_q        <= S_IDLE;
					if (op_q == KIND_CLAIM) begin
						if (cur_bit) begin
							free_total_q <= ft_dec;
							free_left_q  <= 7'(ft_dec);
							status_q     <= ST_DONE;
						end else begin
							free_left_q  <= 7'(free_total_q);
							status_q     <= ST_TAKEN;
						end
					end else begin
						if (!cur_bit) begin
							free_total_q <= ft_inc;
							free_left_q  <= 7'(ft_inc);
							status_q     <= ST_DONE;
						end else begin
							free_left_q  <= 7'(free_total_q);
							status_q     <= ST_FREE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign result_valid = result_valid_q;
	assign status       = status_q;
	assign granted_id   = granted_id_q;
	assign last         = last_q;
	assign free_left    = free_left_q;

	a_unused_kind_silent: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (kind == KIND_UNUSED) |=> !result_valid)
		else $error("unused kind produced a result");

	a_free_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(free_total_q) <= NUM_CHUNKS)
		else $error("free count above pool size");

	a_busy_ends_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> result_valid && last)
		else $error("item ended without a final result");

	a_nongrant_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (status != ST_GRANT) |-> last && (granted_id == 6'd0))
		else $error("status result not marked last");

endmodule
